### src/tpsr_pkg.sv
// Shared constants, corner tables and controller/datapath command types for the
// linear tetrahedron stiffness and residual core. No dependencies.
package tpsr_pkg;

   localparam int COORD_W         = 16;
   localparam int VAL_W           = 32;
   localparam int COND_W          = 32;
   localparam int ENTRY_W         = 48;
   localparam int COORD_FRAC_BITS = 8;
   localparam int OUT_FRAC_BITS   = 24;
   localparam int COND_FRAC_BITS  = 16;
   localparam logic [COND_W-1:0] COND_RESET = 32'h0001_0000;

   localparam logic [1:0] LAST_CORNER = 2'd3;

   // internal widths
   localparam int DIFF_W    = COORD_W + 1;
   localparam int COF_W     = 2 * DIFF_W + 1;
   localparam int SIX_W     = DIFF_W + COF_W + 2;
   localparam int S_W       = 2 * COF_W + 2;
   localparam int MUL_W     = 37;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int S_SPLIT   = 36;
   localparam int KE_SPLIT  = 24;
   localparam int NUM_RAW_W = S_W + COND_W;
   localparam int NUM_SHIFT = OUT_FRAC_BITS - COND_FRAC_BITS;
   localparam int NUM_W     = NUM_RAW_W + NUM_SHIFT;
   localparam int ACC_W     = NUM_RAW_W + 2;
   localparam int DIV_CNT_W = $clog2(NUM_W);
   localparam int NUM_PAIRS = 10;
   localparam int PAIR_W    = $clog2(NUM_PAIRS);

   // opposite-face corners per node
   localparam logic [1:0] CORNER_J [4] = '{2'd1, 2'd0, 2'd0, 2'd0};
   localparam logic [1:0] CORNER_K [4] = '{2'd3, 2'd2, 2'd3, 2'd1};
   localparam logic [1:0] CORNER_L [4] = '{2'd2, 2'd3, 2'd1, 2'd2};

   // upper triangle of the symmetric matrix
   localparam logic [1:0] PAIR_I [NUM_PAIRS] =
      '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
   localparam logic [1:0] PAIR_J [NUM_PAIRS] =
      '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   typedef enum logic [3:0] {
      PH_NONE,
      PH_COF,
      PH_MIN,
      PH_VOL,
      PH_ABS,
      PH_DEN,
      PH_KS,
      PH_KABS,
      PH_KN,
      PH_DIV,
      PH_FIN,
      PH_RES,
      PH_RABS,
      PH_ROUT
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       capture;
      logic [1:0] i;
      logic [1:0] j;
      logic [1:0] t;
      logic       h;
   } cmd_type;

endpackage

### src/tpsr_ctrl.sv
// Sequencer for the stiffness core: steps the datapath through cofactors,
// volume, matrix entries (with long division) and residual rows. Uses tpsr_pkg.
module tpsr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_node_index,
   output logic                 busy,
   output tpsr_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_COF, S_MIN, S_MGAP, S_VOL, S_VGAP, S_ABS, S_DEN,
      S_KS, S_KSW, S_KABS, S_KN, S_KNW, S_DIV, S_FIN,
      S_RES, S_RGAP, S_RABS, S_ROUT
   } state_type;

   state_type                        state_ff;
   logic                             busy_ff;
   logic [1:0]                       i_ff;
   logic [1:0]                       j_ff;
   logic [1:0]                       t_ff;
   logic                             h_ff;
   logic [tpsr_pkg::PAIR_W-1:0]      p_ff;
   logic [tpsr_pkg::DIV_CNT_W-1:0]   n_ff;
   tpsr_pkg::phase_type              phase;

   assign busy = busy_ff;

   always_comb begin
      unique case (state_ff)
         S_COF:   phase = tpsr_pkg::PH_COF;
         S_MIN:   phase = tpsr_pkg::PH_MIN;
         S_VOL:   phase = tpsr_pkg::PH_VOL;
         S_ABS:   phase = tpsr_pkg::PH_ABS;
         S_DEN:   phase = tpsr_pkg::PH_DEN;
         S_KS:    phase = tpsr_pkg::PH_KS;
         S_KABS:  phase = tpsr_pkg::PH_KABS;
         S_KN:    phase = tpsr_pkg::PH_KN;
         S_DIV:   phase = tpsr_pkg::PH_DIV;
         S_FIN:   phase = tpsr_pkg::PH_FIN;
         S_RES:   phase = tpsr_pkg::PH_RES;
         S_RABS:  phase = tpsr_pkg::PH_RABS;
         S_ROUT:  phase = tpsr_pkg::PH_ROUT;
         default: phase = tpsr_pkg::PH_NONE;
      endcase
   end

   always_comb begin
      cmd.phase   = phase;
      cmd.capture = start & ~busy_ff;
      cmd.t       = t_ff;
      cmd.h       = h_ff;
      if (state_ff == S_KS || state_ff == S_KSW || state_ff == S_KABS ||
          state_ff == S_KN || state_ff == S_KNW || state_ff == S_DIV ||
          state_ff == S_FIN) begin
         cmd.i = tpsr_pkg::PAIR_I[p_ff];
         cmd.j = tpsr_pkg::PAIR_J[p_ff];
      end else begin
         cmd.i = i_ff;
         cmd.j = j_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         t_ff     <= '0;
         h_ff     <= 1'b0;
         p_ff     <= '0;
         n_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start && req_node_index == tpsr_pkg::LAST_CORNER) begin
                  state_ff <= S_COF;
                  busy_ff  <= 1'b1;
                  i_ff     <= '0;
                  j_ff     <= '0;
                  t_ff     <= '0;
                  h_ff     <= 1'b0;
                  p_ff     <= '0;
               end
            end
            S_COF: begin
               h_ff <= ~h_ff;
               if (h_ff) begin
                  if (t_ff == 2'd2) begin
                     t_ff <= '0;
                     if (i_ff == 2'd3) begin
                        state_ff <= S_MIN;
                        i_ff     <= '0;
                     end else begin
                        i_ff <= i_ff + 2'd1;
                     end
                  end else begin
                     t_ff <= t_ff + 2'd1;
                  end
               end
            end
            S_MIN: begin
               h_ff <= ~h_ff;
               if (h_ff) begin
                  if (t_ff == 2'd2) begin
                     t_ff     <= '0;
                     state_ff <= S_MGAP;
                  end else begin
                     t_ff <= t_ff + 2'd1;
                  end
               end
            end
            S_MGAP: state_ff <= S_VOL;
            S_VOL: begin
               if (t_ff == 2'd2) begin
                  t_ff     <= '0;
                  state_ff <= S_VGAP;
               end else begin
                  t_ff <= t_ff + 2'd1;
               end
            end
            S_VGAP: state_ff <= S_ABS;
            S_ABS:  state_ff <= S_DEN;
            S_DEN:  state_ff <= S_KS;
            S_KS: begin
               if (t_ff == 2'd2) begin
                  t_ff     <= '0;
                  state_ff <= S_KSW;
               end else begin
                  t_ff <= t_ff + 2'd1;
               end
            end
            S_KSW:  state_ff <= S_KABS;
            S_KABS: begin
               state_ff <= S_KN;
               h_ff     <= 1'b0;
            end
            S_KN: begin
               h_ff <= ~h_ff;
               if (h_ff) state_ff <= S_KNW;
            end
            S_KNW: begin
               state_ff <= S_DIV;
               n_ff     <= '0;
            end
            S_DIV: begin
               if (n_ff == tpsr_pkg::DIV_CNT_W'(tpsr_pkg::NUM_W - 1)) begin
                  state_ff <= S_FIN;
               end else begin
                  n_ff <= n_ff + 1'b1;
               end
            end
            S_FIN: begin
               if (p_ff == tpsr_pkg::PAIR_W'(tpsr_pkg::NUM_PAIRS - 1)) begin
                  state_ff <= S_RES;
                  p_ff     <= '0;
                  i_ff     <= '0;
                  j_ff     <= '0;
                  h_ff     <= 1'b0;
               end else begin
                  p_ff     <= p_ff + 1'b1;
                  state_ff <= S_KS;
               end
            end
            S_RES: begin
               h_ff <= ~h_ff;
               if (h_ff) begin
                  if (j_ff == 2'd3) begin
                     j_ff     <= '0;
                     state_ff <= S_RGAP;
                  end else begin
                     j_ff <= j_ff + 2'd1;
                  end
               end
            end
            S_RGAP: state_ff <= S_RABS;
            S_RABS: state_ff <= S_ROUT;
            S_ROUT: begin
               if (i_ff == 2'd3) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
                  i_ff     <= '0;
               end else begin
                  i_ff     <= i_ff + 2'd1;
                  state_ff <= S_RES;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### src/tpsr_datapath.sv
// Datapath of the stiffness core: corner store, conductivity register, one shared
// signed multiplier with accumulator, restoring divider and output registers.
// Uses tpsr_pkg; driven by tpsr_ctrl commands.
module tpsr_datapath #(
   parameter int COORD_FRAC_BITS = tpsr_pkg::COORD_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tpsr_pkg::cmd_type                   cmd,
   input  logic                                csr_wr_en,
   input  logic [tpsr_pkg::COND_W-1:0]         csr_wr_data,
   input  logic [1:0]                          req_node_index,
   input  logic signed [tpsr_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [tpsr_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [tpsr_pkg::COORD_W-1:0] req_coord_z,
   input  logic signed [tpsr_pkg::VAL_W-1:0]   req_node_value,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_row,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col0,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col1,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col2,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col3,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_residual,
   output logic                                rsp_last_row,
   output logic                                rsp_degenerate
);

   localparam int CW    = tpsr_pkg::COORD_W;
   localparam int EW    = tpsr_pkg::ENTRY_W;
   localparam int DW    = tpsr_pkg::DIFF_W;
   localparam int FW    = tpsr_pkg::COF_W;
   localparam int VW    = tpsr_pkg::SIX_W;
   localparam int SW    = tpsr_pkg::S_W;
   localparam int MW    = tpsr_pkg::MUL_W;
   localparam int PW    = tpsr_pkg::PROD_W;
   localparam int AW    = tpsr_pkg::ACC_W;
   localparam int NW    = tpsr_pkg::NUM_W;
   localparam int NRW   = tpsr_pkg::NUM_RAW_W;
   localparam int QW    = EW + 1;
   localparam int DEN_W = VW + 3 + COORD_FRAC_BITS;
   localparam int RND_W = AW - tpsr_pkg::COND_FRAC_BITS;
   localparam logic [AW-1:0] RES_HALF = AW'(1) << (tpsr_pkg::COND_FRAC_BITS - 1);

   function automatic logic signed [EW-1:0] sat_entry(input logic [AW-1:0] mag,
                                                      input logic neg);
      logic [EW-1:0] lim;
      logic [EW-1:0] v;
      lim = neg ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
      v   = (mag > AW'(lim)) ? lim : mag[EW-1:0];
      return neg ? $signed(-v) : $signed(v);
   endfunction

   // corner store, undefined until written
   logic signed [CW-1:0]               cx_ff [4];
   logic signed [CW-1:0]               cy_ff [4];
   logic signed [CW-1:0]               cz_ff [4];
   logic signed [tpsr_pkg::VAL_W-1:0]  cu_ff [4];
   logic [tpsr_pkg::COND_W-1:0]        cond_ff;

   logic signed [FW-1:0]  cof_ff [4][3];
   logic signed [FW-1:0]  minor_ff [3];
   logic signed [PW-1:0]  prod_ff;
   tpsr_pkg::cmd_type     dcmd_ff;
   logic signed [AW-1:0]  acc_ff;
   logic signed [AW-1:0]  acc_in;
   logic signed [VW-1:0]  six_ff;
   logic [VW-1:0]         absd_ff;
   logic                  degen_ff;
   logic [DEN_W-1:0]      den_ff;
   logic signed [SW-1:0]  s_ff;
   logic [SW-1:0]         smag_ff;
   logic                  neg_ff;
   logic [NW-1:0]         num_ff;
   logic [DEN_W-1:0]      rem_ff;
   logic [QW-1:0]         q_ff;
   logic                  ovf_ff;
   logic signed [EW-1:0]  ke_ff [4][4];
   logic [AW-1:0]         rmag_ff;
   logic                  rneg_ff;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_row_ff;
   logic signed [EW-1:0]  rsp_col0_ff, rsp_col1_ff, rsp_col2_ff, rsp_col3_ff;
   logic signed [EW-1:0]  rsp_res_ff;
   logic                  rsp_last_ff, rsp_degen_ff;

   // operand selection
   logic [1:0]            ia, ib, ic, vi;
   logic                  p_is_x, q_is_y;
   logic signed [CW-1:0]  pa, pb, pc, qa, qb, qc;
   logic signed [DW-1:0]  d1, d2;
   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [EW-1:0]  ke_sel;

   always_comb begin
      ia     = tpsr_pkg::CORNER_J[cmd.i];
      ib     = tpsr_pkg::CORNER_K[cmd.i];
      ic     = tpsr_pkg::CORNER_L[cmd.i];
      p_is_x = (cmd.t != 2'd0);
      q_is_y = (cmd.t == 2'd2);
      if (cmd.phase == tpsr_pkg::PH_MIN) begin
         // minors of the volume determinant, taken about corner 0
         ia     = 2'd0;
         ib     = (cmd.t == 2'd0) ? 2'd2 : 2'd1;
         ic     = (cmd.t == 2'd2) ? 2'd2 : 2'd3;
         p_is_x = 1'b0;
         q_is_y = 1'b0;
      end else if (cmd.t == 2'd1) begin
         // C cofactor has the opposite orientation
         ib = tpsr_pkg::CORNER_L[cmd.i];
         ic = tpsr_pkg::CORNER_K[cmd.i];
      end
      pa = p_is_x ? cx_ff[ia] : cy_ff[ia];
      pb = p_is_x ? cx_ff[ib] : cy_ff[ib];
      pc = p_is_x ? cx_ff[ic] : cy_ff[ic];
      qa = q_is_y ? cy_ff[ia] : cz_ff[ia];
      qb = q_is_y ? cy_ff[ib] : cz_ff[ib];
      qc = q_is_y ? cy_ff[ic] : cz_ff[ic];
      d1 = cmd.h ? (DW'(pc) - DW'(pa)) : (DW'(pb) - DW'(pa));
      d2 = cmd.h ? (DW'(qb) - DW'(qa)) : (DW'(qc) - DW'(qa));
      vi = cmd.t + 2'd1;
      ke_sel = ke_ff[cmd.i][cmd.j];

      case (cmd.phase)
         tpsr_pkg::PH_COF, tpsr_pkg::PH_MIN: begin
            mul_a = MW'(d1);
            mul_b = MW'(d2);
         end
         tpsr_pkg::PH_VOL: begin
            mul_a = MW'(DW'(cx_ff[vi]) - DW'(cx_ff[0]));
            mul_b = MW'(minor_ff[cmd.t]);
         end
         tpsr_pkg::PH_KS: begin
            mul_a = MW'(cof_ff[cmd.i][cmd.t]);
            mul_b = MW'(cof_ff[cmd.j][cmd.t]);
         end
         tpsr_pkg::PH_KN: begin
            mul_a = cmd.h ? MW'(smag_ff[SW-1:tpsr_pkg::S_SPLIT])
                          : MW'(smag_ff[tpsr_pkg::S_SPLIT-1:0]);
            mul_b = MW'(cond_ff);
         end
         tpsr_pkg::PH_RES: begin
            // upper half carries the sign, lower half is unsigned
            mul_a = cmd.h ? MW'($signed(ke_sel[EW-1:tpsr_pkg::KE_SPLIT]))
                          : MW'(ke_sel[tpsr_pkg::KE_SPLIT-1:0]);
            mul_b = MW'(cu_ff[cmd.j]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // accumulate the product registered on the previous cycle
   logic signed [AW-1:0] pe, pe_sh;

   always_comb begin
      pe    = AW'(prod_ff);
      pe_sh = pe;
      if (dcmd_ff.phase == tpsr_pkg::PH_KN && dcmd_ff.h) begin
         pe_sh = pe <<< tpsr_pkg::S_SPLIT;
      end else if (dcmd_ff.phase == tpsr_pkg::PH_RES && dcmd_ff.h) begin
         pe_sh = pe <<< tpsr_pkg::KE_SPLIT;
      end
      case (dcmd_ff.phase)
         tpsr_pkg::PH_COF, tpsr_pkg::PH_MIN:
            acc_in = dcmd_ff.h ? (acc_ff - pe_sh) : pe_sh;
         tpsr_pkg::PH_VOL: begin
            if (dcmd_ff.t == 2'd0)      acc_in = pe_sh;
            else if (dcmd_ff.t == 2'd1) acc_in = acc_ff - pe_sh;
            else                        acc_in = acc_ff + pe_sh;
         end
         tpsr_pkg::PH_KS:
            acc_in = (dcmd_ff.t == 2'd0) ? pe_sh : (acc_ff + pe_sh);
         tpsr_pkg::PH_KN:
            acc_in = dcmd_ff.h ? (acc_ff + pe_sh) : pe_sh;
         tpsr_pkg::PH_RES:
            acc_in = (dcmd_ff.j == 2'd0 && !dcmd_ff.h) ? pe_sh : (acc_ff + pe_sh);
         default:
            acc_in = acc_ff;
      endcase
   end

   // divider step and entry finish
   logic [DEN_W:0]   r2;
   logic             ge;
   logic             rnd;
   logic [QW:0]      qmag;
   logic [AW-1:0]    qsat;
   logic signed [EW-1:0] kval;
   logic [AW-1:0]    rr;

   always_comb begin
      r2   = {rem_ff, num_ff[NW-1]};
      ge   = r2 >= {1'b0, den_ff};
      rnd  = {rem_ff, 1'b0} >= {1'b0, den_ff};
      qmag = {1'b0, q_ff} + (QW+1)'(rnd);
      qsat = ovf_ff ? {AW{1'b1}} : AW'(qmag);
      kval = degen_ff ? '0 : sat_entry(qsat, neg_ff);
      rr   = AW'((rmag_ff + RES_HALF) >> tpsr_pkg::COND_FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cond_ff      <= tpsr_pkg::COND_RESET;
         dcmd_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cond_ff <= csr_wr_data;
         dcmd_ff      <= cmd;
         rsp_valid_ff <= (cmd.phase == tpsr_pkg::PH_ROUT);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cx_ff[req_node_index] <= req_coord_x;
         cy_ff[req_node_index] <= req_coord_y;
         cz_ff[req_node_index] <= req_coord_z;
         cu_ff[req_node_index] <= req_node_value;
      end

      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;

      // write-back of finished sums
      case (dcmd_ff.phase)
         tpsr_pkg::PH_COF: if (dcmd_ff.h) cof_ff[dcmd_ff.i][dcmd_ff.t] <= acc_in[FW-1:0];
         tpsr_pkg::PH_MIN: if (dcmd_ff.h) minor_ff[dcmd_ff.t] <= acc_in[FW-1:0];
         tpsr_pkg::PH_VOL: if (dcmd_ff.t == 2'd2) six_ff <= acc_in[VW-1:0];
         tpsr_pkg::PH_KS:  if (dcmd_ff.t == 2'd2) s_ff <= acc_in[SW-1:0];
         tpsr_pkg::PH_KN: begin
            if (dcmd_ff.h) begin
               num_ff <= {acc_in[NRW-1:0], {tpsr_pkg::NUM_SHIFT{1'b0}}};
               rem_ff <= '0;
               q_ff   <= '0;
               ovf_ff <= 1'b0;
            end
         end
         default: ;
      endcase

      case (cmd.phase)
         tpsr_pkg::PH_ABS: begin
            absd_ff  <= six_ff[VW-1] ? VW'(-six_ff) : VW'(six_ff);
            degen_ff <= (six_ff == '0);
         end
         tpsr_pkg::PH_DEN:
            den_ff <= (DEN_W'({absd_ff, 2'b00}) + DEN_W'({absd_ff, 1'b0}))
                      << COORD_FRAC_BITS;
         tpsr_pkg::PH_KABS: begin
            smag_ff <= s_ff[SW-1] ? SW'(-s_ff) : SW'(s_ff);
            neg_ff  <= s_ff[SW-1];
         end
         tpsr_pkg::PH_DIV: begin
            rem_ff <= ge ? DEN_W'(r2 - {1'b0, den_ff}) : DEN_W'(r2);
            num_ff <= {num_ff[NW-2:0], 1'b0};
            q_ff   <= {q_ff[QW-2:0], ge};
            ovf_ff <= ovf_ff | q_ff[QW-1];
         end
         tpsr_pkg::PH_FIN: begin
            ke_ff[cmd.i][cmd.j] <= kval;
            if (cmd.i != cmd.j) ke_ff[cmd.j][cmd.i] <= kval;
         end
         tpsr_pkg::PH_RABS: begin
            rmag_ff <= acc_ff[AW-1] ? AW'(-acc_ff) : AW'(acc_ff);
            rneg_ff <= acc_ff[AW-1];
         end
         tpsr_pkg::PH_ROUT: begin
            rsp_row_ff   <= cmd.i;
            rsp_col0_ff  <= ke_ff[cmd.i][0];
            rsp_col1_ff  <= ke_ff[cmd.i][1];
            rsp_col2_ff  <= ke_ff[cmd.i][2];
            rsp_col3_ff  <= ke_ff[cmd.i][3];
            rsp_res_ff   <= sat_entry(rr, rneg_ff);
            rsp_last_ff  <= (cmd.i == 2'd3);
            rsp_degen_ff <= degen_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row        = rsp_row_ff;
   assign rsp_entry_col0 = rsp_col0_ff;
   assign rsp_entry_col1 = rsp_col1_ff;
   assign rsp_entry_col2 = rsp_col2_ff;
   assign rsp_entry_col3 = rsp_col3_ff;
   assign rsp_residual   = rsp_res_ff;
   assign rsp_last_row   = rsp_last_ff;
   assign rsp_degenerate = rsp_degen_ff;

endmodule

### src/tet_p1_stiffness_residual_core.sv
// Linear tetrahedron heat stiffness core. Corner 0..2 transactions are stored without raising busy.
// The corner 3 transaction holds busy through cofactors and volume, the upper-triangle
// entries (each with the bit-serial restoring divider) and the residual rows.
// Rows come out on rsp_valid; the receiver cannot stall.
// Synchronous reset idles the sequencer and sets conductivity to 1.0; the corner
// store is undefined until written. Uses tpsr_pkg, tpsr_ctrl, tpsr_datapath.
module tet_p1_stiffness_residual_core #(
   parameter int COORD_FRAC_BITS = tpsr_pkg::COORD_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_node_index,
   input  logic signed [tpsr_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [tpsr_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [tpsr_pkg::COORD_W-1:0] req_coord_z,
   input  logic signed [tpsr_pkg::VAL_W-1:0]   req_node_value,
   input  logic                                csr_wr_en,
   input  logic [tpsr_pkg::COND_W-1:0]         csr_wr_data,
   output logic                                rsp_valid,
   output logic [1:0]                          rsp_row,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col0,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col1,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col2,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col3,
   output logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_residual,
   output logic                                rsp_last_row,
   output logic                                rsp_degenerate
);

   tpsr_pkg::cmd_type cmd;

   tpsr_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_node_index (req_node_index),
      .busy           (busy),
      .cmd            (cmd)
   );

   tpsr_datapath #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_node_index (req_node_index),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .req_node_value (req_node_value),
      .rsp_valid      (rsp_valid),
      .rsp_row        (rsp_row),
      .rsp_entry_col0 (rsp_entry_col0),
      .rsp_entry_col1 (rsp_entry_col1),
      .rsp_entry_col2 (rsp_entry_col2),
      .rsp_entry_col3 (rsp_entry_col3),
      .rsp_residual   (rsp_residual),
      .rsp_last_row   (rsp_last_row),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule

### verif/tet_p1_stiffness_residual_core_tb.sv
// Testbench for the linear tetrahedron stiffness and residual core: drives
// corner transactions, predicts the four stiffness rows and checks them.
// Depends on tpsr_pkg and tet_p1_stiffness_residual_core.
module tet_p1_stiffness_residual_core_tb;

   typedef struct {
      logic [1:0]                          row;
      logic signed [tpsr_pkg::ENTRY_W-1:0] col [4];
      logic signed [tpsr_pkg::ENTRY_W-1:0] residual;
      logic                                last_row;
      logic                                degenerate;
   } row_type;

   int unsigned errors = 0;

   task automatic report(input string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
   endtask

   class stiffness_scoreboard;
      logic signed [tpsr_pkg::COORD_W-1:0] cx [4], cy [4], cz [4];
      logic signed [tpsr_pkg::VAL_W-1:0]   val [4];
      logic [tpsr_pkg::COND_W-1:0]         cond = tpsr_pkg::COND_RESET;
      row_type                             rows_due [$];
      int unsigned                         rows_seen = 0, elements = 0, degen_elements = 0;

      function logic signed [tpsr_pkg::ENTRY_W-1:0] sat48(logic [127:0] m, bit neg);
         logic [127:0] lim;
         lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
         if (m > lim) m = lim;
         return neg ? tpsr_pkg::ENTRY_W'(-m) : tpsr_pkg::ENTRY_W'(m);
      endfunction

      function void note_input(logic [1:0] idx, logic signed [tpsr_pkg::COORD_W-1:0] x,
                               logic signed [tpsr_pkg::COORD_W-1:0] y,
                               logic signed [tpsr_pkg::COORD_W-1:0] z,
                               logic signed [tpsr_pkg::VAL_W-1:0] v);
         logic signed [127:0] px [4], py [4], pz [4], cb [4], cc [4], cd [4], six_v, s, acc;
         logic [127:0] absd, mag, num, den, q, r;
         logic signed [tpsr_pkg::ENTRY_W-1:0] ke [4][4];
         bit neg, degen;
         int a, b, c;
         row_type e;
         cx[idx] = x; cy[idx] = y; cz[idx] = z; val[idx] = v;
         if (idx != tpsr_pkg::LAST_CORNER) return;
         elements++;
         for (int i = 0; i < 4; i++) begin
            px[i] = cx[i]; py[i] = cy[i]; pz[i] = cz[i];
         end
         six_v = (px[1]-px[0]) * ((py[2]-py[0])*(pz[3]-pz[0]) - (py[3]-py[0])*(pz[2]-pz[0]))
               - (px[2]-px[0]) * ((py[1]-py[0])*(pz[3]-pz[0]) - (py[3]-py[0])*(pz[1]-pz[0]))
               + (px[3]-px[0]) * ((py[1]-py[0])*(pz[2]-pz[0]) - (py[2]-py[0])*(pz[1]-pz[0]));
         degen = (six_v == 0);
         if (degen) degen_elements++;
         absd = six_v < 0 ? -six_v : six_v;
         for (int i = 0; i < 4; i++) begin
            a = tpsr_pkg::CORNER_J[i]; b = tpsr_pkg::CORNER_K[i]; c = tpsr_pkg::CORNER_L[i];
            cb[i] = (py[b]-py[a])*(pz[c]-pz[a]) - (py[c]-py[a])*(pz[b]-pz[a]);
            cc[i] = (px[c]-px[a])*(pz[b]-pz[a]) - (px[b]-px[a])*(pz[c]-pz[a]);
            cd[i] = (px[b]-px[a])*(py[c]-py[a]) - (px[c]-px[a])*(py[b]-py[a]);
         end
         den = (absd * 128'd6) << tpsr_pkg::COORD_FRAC_BITS;
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
               if (degen) begin
                  ke[i][j] = '0;
                  continue;
               end
               s   = cb[i]*cb[j] + cc[i]*cc[j] + cd[i]*cd[j];
               neg = s < 0;
               mag = neg ? -s : s;
               num = (mag * {96'd0, cond}) <<
                     (tpsr_pkg::OUT_FRAC_BITS - tpsr_pkg::COND_FRAC_BITS);
               q = num / den;
               r = num % den;
               if ((r << 1) >= den) q++;   // round half away from zero on magnitude
               ke[i][j] = sat48(q, neg);
            end
         for (int i = 0; i < 4; i++) begin
            acc = 0;
            for (int j = 0; j < 4; j++) begin
               s = ke[i][j];
               acc += s * 128'(signed'(val[j]));
            end
            neg = acc < 0;
            mag = neg ? -acc : acc;
            mag = (mag + (128'd1 << (tpsr_pkg::COND_FRAC_BITS - 1))) >>
                  tpsr_pkg::COND_FRAC_BITS;
            e.row = i[1:0];
            for (int j = 0; j < 4; j++) e.col[j] = ke[i][j];
            e.residual   = sat48(mag, neg);
            e.last_row   = (i == 3);
            e.degenerate = degen;
            rows_due = {rows_due, e};
         end
      endfunction

      task check(row_type got);
         row_type w;
         rows_seen++;
         if (rows_due.size() == 0) begin
            report($sformatf("unexpected row %0d", got.row));
            return;
         end
         w = rows_due.pop_front();
         if (got.row !== w.row) report($sformatf("row %0d, want %0d", got.row, w.row));
         for (int j = 0; j < 4; j++)
            if (got.col[j] !== w.col[j])
               report($sformatf("row %0d col%0d %0d, want %0d", w.row, j, got.col[j], w.col[j]));
         if (got.residual !== w.residual)
            report($sformatf("row %0d residual %0d, want %0d", w.row, got.residual, w.residual));
         if (got.last_row !== w.last_row)
            report($sformatf("row %0d last_row %b, want %b", w.row, got.last_row, w.last_row));
         if (got.degenerate !== w.degenerate)
            report($sformatf("row %0d degenerate %b, want %b", w.row, got.degenerate,
                             w.degenerate));
      endtask
   endclass

   logic clock = 0, reset = 1, start = 0, busy, csr_wr_en = 0;
   logic [1:0] req_node_index = '0;
   logic signed [tpsr_pkg::COORD_W-1:0] req_coord_x = '0, req_coord_y = '0, req_coord_z = '0;
   logic signed [tpsr_pkg::VAL_W-1:0] req_node_value = '0;
   logic [tpsr_pkg::COND_W-1:0] csr_wr_data = '0;
   logic rsp_valid, rsp_last_row, rsp_degenerate;
   logic [1:0] rsp_row;
   logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col0, rsp_entry_col1;
   logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_entry_col2, rsp_entry_col3;
   logic signed [tpsr_pkg::ENTRY_W-1:0] rsp_residual;

   stiffness_scoreboard sb = new();
   int unsigned cycles = 0, burst_left = 0;

   tet_p1_stiffness_residual_core dut (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      row_type got;
      cycles++;
      if (cycles > 1500000) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
      if (!reset) begin
         if (start && !busy)
            sb.note_input(req_node_index, req_coord_x, req_coord_y, req_coord_z,
                          req_node_value);
         if (rsp_valid) begin
            got.row = rsp_row;
            got.col[0] = rsp_entry_col0; got.col[1] = rsp_entry_col1;
            got.col[2] = rsp_entry_col2; got.col[3] = rsp_entry_col3;
            got.residual = rsp_residual;
            got.last_row = rsp_last_row;
            got.degenerate = rsp_degenerate;
            sb.check(got);
         end
      end
   end

   // one corner transaction; returns at the edge it was taken unless a burst ends
   task automatic send_corner(input logic [1:0] idx, input logic signed [15:0] x,
                              input logic signed [15:0] y, input logic signed [15:0] z,
                              input logic signed [31:0] v);
      start <= 1;
      req_node_index <= idx;
      req_coord_x <= x; req_coord_y <= y; req_coord_z <= z;
      req_node_value <= v;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      if (burst_left == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 25)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else
         burst_left--;
   endtask

   // stop sending and wait until every expected row has come back
   task automatic drain;
      start <= 0;
      forever begin
         @(negedge clock);
         if (sb.rows_due.size() == 0 && !busy) break;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic write_cond(input logic [31:0] k);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.cond = k;
   endtask

   task automatic send_tet(input logic signed [15:0] p [12], input logic signed [31:0] u [4]);
      for (int i = 0; i < 4; i++)
         send_corner(i[1:0], p[3*i], p[3*i+1], p[3*i+2], u[i]);
   endtask

   function automatic logic signed [15:0] rand_coord(bit wide);
      return wide ? 16'($urandom) : 16'($urandom_range(0, 4095)) - 16'sd2048;
   endfunction

   task automatic random_phase(input int items);
      logic signed [15:0] p [12];
      logic signed [31:0] u [4];
      int sent;
      bit wide;
      sent = 0;
      while (sent < items) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: corners in arbitrary order
            repeat ($urandom_range(1, 5)) begin
               send_corner(2'($urandom), rand_coord(1), rand_coord(1), rand_coord(1),
                           32'($urandom));
               sent++;
            end
         end else begin
            wide = $urandom_range(0, 3) == 0;
            foreach (p[i]) p[i] = rand_coord(wide);
            foreach (u[i]) u[i] = $urandom_range(0, 1) ? 32'($urandom)
                                  : 32'($urandom_range(0, 2**20)) - 32'sd524288;
            if ($urandom_range(0, 9) == 0) begin
               p[6] = p[3]; p[7] = p[4]; p[8] = p[5];   // collapsed element
            end
            send_tet(p, u);
            sent += 4;
         end
      end
   endtask

   initial begin
      logic signed [15:0] p [12];
      logic signed [31:0] u [4];
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // unit tetrahedron at reset conductivity, then mirrored corner order
      p = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256};
      u = '{32'sh10000, 0, -32'sh10000, 32'sh7FFFFFFF};
      send_tet(p, u);
      p = '{0, 0, 0, 0, 256, 0, 256, 0, 0, 0, 0, 256};
      send_tet(p, u);
      // flat element
      p = '{0, 0, 0, 256, 0, 0, 512, 0, 0, 0, 0, 256};
      send_tet(p, u);
      // field extremes, sliver at maximum conductivity
      write_cond(32'hFFFF_FFFF);
      p = '{-32768, -32768, 0, 32767, 32767, 0, 32767, -32768, 0, 0, 0, 1};
      u = '{32'sh7FFFFFFF, -32'sh80000000, 32'sh7FFFFFFF, -32'sh80000000};
      send_tet(p, u);
      p = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768,
            -32768, -32768, 32767};
      send_tet(p, u);
      // repeated corner: slot 1 rewritten before the compute
      send_corner(0, 0, 0, 0, 5);
      send_corner(1, 100, 0, 0, 6);
      send_corner(1, 300, 0, 0, -7);
      send_corner(2, 0, 200, 0, 8);
      send_corner(3, 0, 0, 400, 9);
      write_cond(32'd0);
      p = '{0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 256};
      send_tet(p, u);

      write_cond(32'd65536);
      random_phase(90);
      write_cond(32'hFFFF_FFFF);
      random_phase(80);
      write_cond($urandom);
      random_phase(90);
      write_cond(32'd1);
      random_phase(80);
      drain();

      $display("Covered %0d elements (%0d collapsed), %0d rows checked, 5 conductivities.",
               sb.elements, sb.degen_elements, sb.rows_seen);
      if (errors == 0 && sb.rows_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
